FILE: rtl/obe_pkg.sv
// obe_pkg: constants, types and CORDIC table for the oriented box extents core.
// No dependencies.
package obe_pkg;

  localparam int CoordW   = 24;
  localparam int CordicN  = 16;
  localparam int CordicW  = 34;
  localparam int TrigW    = 18;
  localparam int SumW     = 19;
  localparam int DotW     = 45;
  localparam int UnitQ16  = 65536;
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [CoordW+1:0] CoordMax = 26'sd8388607;
  localparam logic signed [CoordW+1:0] CoordMin = -26'sd8388608;

  typedef logic signed [CordicW-1:0] cw_t;
  typedef logic signed [TrigW-1:0]   trig_t;

  // One CORDIC lane: x, y, residual angle, quadrant, zero flag.
  typedef struct packed {
    cw_t         x;
    cw_t         y;
    logic signed [24:0] z;
    logic [1:0]  quad;
    logic        zero;
  } cordic_t;

  function automatic logic signed [24:0] atan_val(input int i);
    case (i)
      0:  atan_val = 25'sd2097152;
      1:  atan_val = 25'sd1238021;
      2:  atan_val = 25'sd654136;
      3:  atan_val = 25'sd332050;
      4:  atan_val = 25'sd166669;
      5:  atan_val = 25'sd83416;
      6:  atan_val = 25'sd41718;
      7:  atan_val = 25'sd20860;
      8:  atan_val = 25'sd10430;
      9:  atan_val = 25'sd5215;
      10: atan_val = 25'sd2608;
      11: atan_val = 25'sd1304;
      12: atan_val = 25'sd652;
      13: atan_val = 25'sd326;
      14: atan_val = 25'sd163;
      15: atan_val = 25'sd81;
      default: atan_val = 25'sd0;
    endcase
  endfunction

  // Q.16 product, rounded half up.
  function automatic trig_t mulq16(input trig_t a, input trig_t b);
    logic signed [2*TrigW-1:0] p;
    begin
      p = a * b + 36'sd32768;
      mulq16 = trig_t'(p >>> 16);
    end
  endfunction

endpackage

FILE: rtl/oriented_box_extents_core.sv
// oriented_box_extents_core: top level, axis-aligned extents of an oriented box.
// Depends on obe_pkg.
//
// Usage: present a box on the in_ channel (center, pitch/yaw/roll binary
// angles, full length/width/height); one transaction on the out_ channel
// returns per-axis min and max of the two opposite corners, saturated.
// A transaction moves when valid is high and stall is low.
// Throughput: one box per cycle while out_stall does not hold the pipeline. Stages from acceptance to out_valid:
// one CORDIC load stage, 16 CORDIC rotation stages, one rounding/quadrant stage,
// two basis product stages, one size-dot stage, one sum/halve stage, and the
// offset/saturate output register.
// The 16-step CORDIC pipeline, one rotation per stage, sets most of the latency.
// Reset (rst_n low, synchronous) clears all valid bits; payload is not reset.
// When out_stall is high while out_valid is set, the whole pipeline holds and
// in_stall goes high; a stall with no valid output does not hold anything.
module oriented_box_extents_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [23:0]        in_center_x,
  input  logic signed [23:0]        in_center_y,
  input  logic signed [23:0]        in_center_z,
  input  logic [15:0]               in_pitch_angle,
  input  logic [15:0]               in_yaw_angle,
  input  logic [15:0]               in_roll_angle,
  input  logic [22:0]               in_box_length,
  input  logic [22:0]               in_box_width,
  input  logic [22:0]               in_box_height,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [23:0]        out_min_x,
  output logic signed [23:0]        out_min_y,
  output logic signed [23:0]        out_min_z,
  output logic signed [23:0]        out_max_x,
  output logic signed [23:0]        out_max_y,
  output logic signed [23:0]        out_max_z
);

  localparam int N = obe_pkg::CordicN;
  localparam int NS = N + 7;  // total stages including output register

  // Pipeline advances unless the output is held and full.
  logic adv;
  logic [NS-1:0] vld_r;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NS-2:0], in_valid};
    end
  end

  // Side data carried along the CORDIC stages.
  typedef struct packed {
    logic signed [23:0] cx, cy, cz;
    logic [22:0] len, wid, hgt;
  } side_t;

  obe_pkg::cordic_t cd_r [N+1][3];
  side_t sd_r [N+1];

  // Stage 0: load CORDIC start values.
  always_ff @(posedge clk) begin
    if (adv) begin
      cd_r[0][0] <= '{x: obe_pkg::CordicGain, y: '0,
                      z: {3'b000, in_pitch_angle[13:0], 8'h00},
                      quad: in_pitch_angle[15:14], zero: (in_pitch_angle[13:0] == '0)};
      cd_r[0][1] <= '{x: obe_pkg::CordicGain, y: '0,
                      z: {3'b000, in_yaw_angle[13:0], 8'h00},
                      quad: in_yaw_angle[15:14], zero: (in_yaw_angle[13:0] == '0)};
      cd_r[0][2] <= '{x: obe_pkg::CordicGain, y: '0,
                      z: {3'b000, in_roll_angle[13:0], 8'h00},
                      quad: in_roll_angle[15:14], zero: (in_roll_angle[13:0] == '0)};
      sd_r[0] <= '{cx: in_center_x, cy: in_center_y, cz: in_center_z,
                   len: in_box_length, wid: in_box_width, hgt: in_box_height};
    end
  end

  // CORDIC rotation stages, one step each.
  for (genvar i = 0; i < N; i++) begin : g_rot
    for (genvar a = 0; a < 3; a++) begin : g_ax
      obe_pkg::cordic_t c_nxt;
      always_comb begin
        c_nxt = cd_r[i][a];
        if (!cd_r[i][a].z[24]) begin
          c_nxt.x = cd_r[i][a].x - (cd_r[i][a].y >>> i);
          c_nxt.y = cd_r[i][a].y + (cd_r[i][a].x >>> i);
          c_nxt.z = cd_r[i][a].z - obe_pkg::atan_val(i);
        end else begin
          c_nxt.x = cd_r[i][a].x + (cd_r[i][a].y >>> i);
          c_nxt.y = cd_r[i][a].y - (cd_r[i][a].x >>> i);
          c_nxt.z = cd_r[i][a].z + obe_pkg::atan_val(i);
        end
      end
      always_ff @(posedge clk) begin
        if (adv) cd_r[i+1][a] <= c_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (adv) sd_r[i+1] <= sd_r[i];
    end
  end

  // Rounding and quadrant mapping: sin/cos per angle (pitch, yaw, roll).
  obe_pkg::trig_t sn_r [3];
  obe_pkg::trig_t cs_r [3];
  side_t sd1_r;
  for (genvar a = 0; a < 3; a++) begin : g_q
    obe_pkg::trig_t s0, c0, s_nxt, c_nxt;
    obe_pkg::cw_t   ys, xs;
    always_comb begin
      ys = (cd_r[N][a].y + 34'sd8192) >>> 14;
      xs = (cd_r[N][a].x + 34'sd8192) >>> 14;
      if (cd_r[N][a].zero) begin
        s0 = '0;
        c0 = obe_pkg::trig_t'(obe_pkg::UnitQ16);
      end else begin
        s0 = ys[obe_pkg::TrigW-1:0];
        c0 = xs[obe_pkg::TrigW-1:0];
      end
      case (cd_r[N][a].quad)
        2'd0: begin s_nxt = s0;  c_nxt = c0;  end
        2'd1: begin s_nxt = c0;  c_nxt = -s0; end
        2'd2: begin s_nxt = -s0; c_nxt = -c0; end
        default: begin s_nxt = -c0; c_nxt = s0; end
      endcase
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sn_r[a] <= s_nxt;
        cs_r[a] <= c_nxt;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) sd1_r <= sd_r[N];
  end

  // First product stage.
  obe_pkg::trig_t sy_r, cy_r, sr_r, cr_r;
  obe_pkg::trig_t fx_r, fy_r, fz_r, rz_r, uz_r, ts_r, tc_r;
  side_t sd2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      sy_r <= sn_r[1]; cy_r <= cs_r[1];
      sr_r <= sn_r[2]; cr_r <= cs_r[2];
      fx_r <= obe_pkg::mulq16(cs_r[0], cs_r[1]);
      fy_r <= obe_pkg::mulq16(cs_r[0], sn_r[1]);
      fz_r <= -sn_r[0];
      rz_r <= -obe_pkg::mulq16(sn_r[2], cs_r[0]);
      uz_r <= obe_pkg::mulq16(cs_r[2], cs_r[0]);
      ts_r <= obe_pkg::mulq16(sn_r[2], sn_r[0]);
      tc_r <= obe_pkg::mulq16(cs_r[2], sn_r[0]);
      sd2_r <= sd1_r;
    end
  end

  // Second product stage: remaining basis components.
  logic signed [obe_pkg::SumW-1:0] f_r [3], r_r [3], u_r [3];
  side_t sd3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= obe_pkg::SumW'(fx_r);
      f_r[1] <= obe_pkg::SumW'(fy_r);
      f_r[2] <= obe_pkg::SumW'(fz_r);
      r_r[0] <= obe_pkg::SumW'(obe_pkg::mulq16(cr_r, sy_r))
              - obe_pkg::SumW'(obe_pkg::mulq16(ts_r, cy_r));
      r_r[1] <= -obe_pkg::SumW'(obe_pkg::mulq16(ts_r, sy_r))
              - obe_pkg::SumW'(obe_pkg::mulq16(cr_r, cy_r));
      r_r[2] <= obe_pkg::SumW'(rz_r);
      u_r[0] <= obe_pkg::SumW'(obe_pkg::mulq16(tc_r, cy_r))
              + obe_pkg::SumW'(obe_pkg::mulq16(sr_r, sy_r));
      u_r[1] <= obe_pkg::SumW'(obe_pkg::mulq16(tc_r, sy_r))
              - obe_pkg::SumW'(obe_pkg::mulq16(sr_r, cy_r));
      u_r[2] <= obe_pkg::SumW'(uz_r);
      sd3_r <= sd2_r;
    end
  end

  // Size dot products: one 24x19 product per term, registered before summing.
  logic signed [42:0] pl_r [3], pw_r [3], ph_r [3];
  side_t sd4_r;
  for (genvar k = 0; k < 3; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (adv) begin
        pl_r[k] <= $signed({1'b0, sd3_r.len}) * f_r[k];
        pw_r[k] <= $signed({1'b0, sd3_r.wid}) * r_r[k];
        ph_r[k] <= $signed({1'b0, sd3_r.hgt}) * u_r[k];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (adv) sd4_r <= sd3_r;
  end

  // Sum, halve, absolute value.
  logic signed [obe_pkg::CoordW+1:0] h_r [3];
  side_t sd5_r;
  for (genvar k = 0; k < 3; k++) begin : g_half
    logic signed [obe_pkg::DotW-1:0] d, hs;
    always_comb begin
      d  = obe_pkg::DotW'(pl_r[k]) + obe_pkg::DotW'(pw_r[k]) + obe_pkg::DotW'(ph_r[k])
         + 45'sd65536;
      hs = d >>> 17;
      if (hs[obe_pkg::DotW-1]) hs = -hs;
    end
    always_ff @(posedge clk) begin
      if (adv) h_r[k] <= hs[obe_pkg::CoordW+1:0];
    end
  end
  always_ff @(posedge clk) begin
    if (adv) sd5_r <= sd4_r;
  end

  // Corner offsets with saturation into the output register.
  logic signed [23:0] mn_r [3], mx_r [3];
  for (genvar k = 0; k < 3; k++) begin : g_out
    logic signed [obe_pkg::CoordW+1:0] c, lo, hi;
    logic signed [23:0] lo_s, hi_s;
    always_comb begin
      c  = (obe_pkg::CoordW+2)'(k == 0 ? sd5_r.cx : (k == 1 ? sd5_r.cy : sd5_r.cz));
      lo = c - h_r[k];
      hi = c + h_r[k];
      lo_s = (lo < obe_pkg::CoordMin) ? 24'sh800000 : lo[23:0];
      hi_s = (hi > obe_pkg::CoordMax) ? 24'sh7FFFFF : hi[23:0];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        mn_r[k] <= lo_s;
        mx_r[k] <= hi_s;
      end
    end
  end

  assign out_min_x = mn_r[0];
  assign out_min_y = mn_r[1];
  assign out_min_z = mn_r[2];
  assign out_max_x = mx_r[0];
  assign out_max_y = mx_r[1];
  assign out_max_z = mx_r[2];

  // Checks
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_x) && $stable(out_max_z))
    else $error("output changed while stalled");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_x <= out_max_x && out_min_y <= out_max_y && out_min_z <= out_max_z)
    else $error("min above max");
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

endmodule

FILE: tb/oriented_box_extents_core_test.sv
// oriented_box_extents_core_test: self-checking bench for the oriented box extents core.
// Depends on obe_pkg and oriented_box_extents_core; predicts bounds with its own CORDIC.
`timescale 1ns / 100ps

module oriented_box_extents_core_test;

  localparam int WatchLimit = 20000;
  localparam int DrainCycles = 40;
  localparam int RandBoxes = 1700;

  typedef struct packed {
    logic signed [23:0] cx, cy, cz;
    logic [15:0] pa, ya, ra;
    logic [22:0] ln, wd, ht;
  } box_t;

  typedef struct packed {
    logic signed [23:0] mnx, mny, mnz, mxx, mxy, mxz;
  } bounds_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  box_t in_box = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bounds_t got;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  oriented_box_extents_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_center_x(in_box.cx), .in_center_y(in_box.cy), .in_center_z(in_box.cz),
    .in_pitch_angle(in_box.pa), .in_yaw_angle(in_box.ya), .in_roll_angle(in_box.ra),
    .in_box_length(in_box.ln), .in_box_width(in_box.wd), .in_box_height(in_box.ht),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_min_x(got.mnx), .out_min_y(got.mny), .out_min_z(got.mnz),
    .out_max_x(got.mxx), .out_max_y(got.mxy), .out_max_z(got.mxz)
  );

  bounds_t pending_bounds[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit hold_off = 0;

  // floor shift on 64-bit signed
  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q16_mul(longint a, longint b);
    return floor_shr(a * b + 32768, 16);
  endfunction

  function automatic void trig(logic [15:0] ang, output longint s, output longint c);
    longint x, y, z, dx, dy, s0, c0;
    logic [1:0] q;
    logic [13:0] r;
    q = ang[15:14];
    r = ang[13:0];
    if (r == 0) begin
      s0 = 0;
      c0 = obe_pkg::UnitQ16;
    end else begin
      x = 652032874;
      y = 0;
      z = longint'(r) * 256;
      for (int i = 0; i < obe_pkg::CordicN; i++) begin
        dx = floor_shr(y, i);
        dy = floor_shr(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(obe_pkg::atan_val(i));
        end else begin
          x += dx; y -= dy; z += longint'(obe_pkg::atan_val(i));
        end
      end
      s0 = floor_shr(y + 8192, 14);
      c0 = floor_shr(x + 8192, 14);
    end
    case (q)
      2'd0: begin s = s0; c = c0; end
      2'd1: begin s = c0; c = -s0; end
      2'd2: begin s = -s0; c = -c0; end
      default: begin s = -c0; c = s0; end
    endcase
  endfunction

  function automatic longint clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic bounds_t box_bounds(box_t b);
    longint sp, cp, sy, cy, sr, cr, t, d, h;
    longint f[3], rv[3], u[3], ctr[3];
    longint lo[3], hi[3];
    bounds_t res;
    trig(b.pa, sp, cp);
    trig(b.ya, sy, cy);
    trig(b.ra, sr, cr);
    ctr[0] = b.cx; ctr[1] = b.cy; ctr[2] = b.cz;
    f[0] = q16_mul(cp, cy); f[1] = q16_mul(cp, sy); f[2] = -sp;
    t = q16_mul(sr, sp);
    rv[0] = -q16_mul(t, cy) + q16_mul(cr, sy);
    rv[1] = -q16_mul(t, sy) - q16_mul(cr, cy);
    rv[2] = -q16_mul(sr, cp);
    t = q16_mul(cr, sp);
    u[0] = q16_mul(t, cy) + q16_mul(sr, sy);
    u[1] = q16_mul(t, sy) - q16_mul(sr, cy);
    u[2] = q16_mul(cr, cp);
    for (int k = 0; k < 3; k++) begin
      d = longint'(b.ln) * f[k] + longint'(b.wd) * rv[k] + longint'(b.ht) * u[k];
      h = floor_shr(d + 65536, 17);
      if (h < 0) h = -h;
      lo[k] = clamp24(ctr[k] - h);
      hi[k] = clamp24(ctr[k] + h);
    end
    res.mnx = 24'(lo[0]); res.mny = 24'(lo[1]); res.mnz = 24'(lo[2]);
    res.mxx = 24'(hi[0]); res.mxy = 24'(hi[1]); res.mxz = 24'(hi[2]);
    return res;
  endfunction

  // directed rows; typed result only where obvious
  typedef struct {
    box_t b;
    bit typed;
    bounds_t r;
  } row_t;

  function automatic box_t mk(int cx, int cy, int cz, int pa, int ya, int ra,
                              int ln, int wd, int ht);
    box_t b;
    b.cx = 24'(cx); b.cy = 24'(cy); b.cz = 24'(cz);
    b.pa = 16'(pa); b.ya = 16'(ya); b.ra = 16'(ra);
    b.ln = 23'(ln); b.wd = 23'(wd); b.ht = 23'(ht);
    return b;
  endfunction

  row_t rows[$];

  function automatic box_t rand_box(bit shaped);
    box_t b;
    b = box_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    if (shaped) begin
      case ($urandom_range(0, 3))
        0: begin b.ln = 23'($urandom_range(0, 4096)); b.wd = 23'($urandom_range(0, 4096));
                 b.ht = 23'($urandom_range(0, 4096)); end
        1: begin b.pa[13:0] = '0; b.ya[13:0] = '0; end
        2: b.cx = $urandom_range(0, 1) ? 24'sh7FFFF0 : -24'sh7FFFF0;
        default: ;
      endcase
    end
    return b;
  endfunction

  task automatic offer(box_t b);
    in_valid <= 1'b1;
    in_box <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // sender
  initial begin
    row_t rw;
    int burst, gap;
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, '0});
    rows.push_back('{mk(8388607, -8388608, 1234, 0, 0, 0, 0, 0, 0), 1'b1,
                     {24'sh7FFFFF, 24'sh800000, 24'sd1234,
                      24'sh7FFFFF, 24'sh800000, 24'sd1234}});
    // identity orientation: |h| = length/2 on x, width/2 on y, height/2 on z
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, 512, 1024, 2048), 1'b1,
                     {-24'sd256, -24'sd512, -24'sd1024, 24'sd256, 24'sd512, 24'sd1024}});
    // y offset rounds one lower since the right vector points along -y
    rows.push_back('{mk(8388607, 8388607, 8388607, 0, 0, 0,
                        8388607, 8388607, 8388607), 1'b1,
                     {24'sd4194303, 24'sd4194304, 24'sd4194303,
                      24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF}});
    rows.push_back('{mk(-8388608, -8388608, -8388608, 0, 0, 0,
                        8388607, 8388607, 8388607), 1'b1,
                     {24'sh800000, 24'sh800000, 24'sh800000,
                      -24'sd4194304, -24'sd4194305, -24'sd4194304}});
    // quadrant boundaries and general angles, predicted
    for (int q = 0; q < 4; q++)
      rows.push_back('{mk(100, -200, 300, q * 16384, (q + 1) * 16384 % 65536,
                          (q + 2) * 16384 % 65536, 5000, 3000, 1000), 1'b0, '0});
    rows.push_back('{mk(0, 0, 0, 65535, 65535, 65535, 8388607, 8388607, 8388607),
                     1'b0, '0});
    rows.push_back('{mk(0, 0, 0, 1, 1, 1, 8388607, 0, 0), 1'b0, '0});
    rows.push_back('{mk(0, 0, 0, 8192, 24576, 40960, 65536, 65536, 65536), 1'b0, '0});
    rows.push_back('{mk(-5, 7, -9, 16383, 16385, 32767, 1, 1, 1), 1'b0, '0});
    rows.push_back('{mk(8388607, -8388608, 0, 12345, 54321, 33333,
                        8388607, 8388607, 8388607), 1'b0, '0});
    rows.push_back('{mk(0, 0, 0, 49152, 0, 16384, 256, 512, 768), 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      rw = rows[i];
      pending_bounds.push_back(rw.typed ? rw.r : box_bounds(rw.b));
      offer(rw.b);
    end
    // random part in bursts
    for (int n = 0; n < RandBoxes; ) begin
      burst = $urandom_range(1, 40);
      for (int j = 0; j < burst && n < RandBoxes; j++, n++) begin
        box_t b;
        b = rand_box($urandom_range(0, 3) != 0);
        pending_bounds.push_back(box_bounds(b));
        offer(b);
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;
    while (pending_bounds.size() != 0 && !timed_out) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && !timed_out)
      $display("[oriented_box_extents_core] OK");
    else
      $display("[oriented_box_extents_core] ERROR");
    $finish;
  end

  // receiver stall pattern, with one long hold-off
  initial begin
    int cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 400) hold_off = 1;
      if (cyc == 520) hold_off = 0;
      if (hold_off) out_stall <= 1'b1;
      else if ((cyc / 300) % 3 == 2) out_stall <= 1'b0;
      else out_stall <= ($urandom_range(0, 3) == 0);
    end
  end

  // result checker and watchdog
  always @(posedge clk) begin
    bounds_t exp_b;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        timed_out = 1;
        $display("[oriented_box_extents_core] ERROR");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_bounds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction %h", got);
        end else begin
          exp_b = pending_bounds.pop_front();
          if (got !== exp_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch min %0d %0d %0d / %0d %0d %0d max %0d %0d %0d / %0d %0d %0d",
                       exp_b.mnx, exp_b.mny, exp_b.mnz, got.mnx, got.mny, got.mnz,
                       exp_b.mxx, exp_b.mxy, exp_b.mxz, got.mxx, got.mxy, got.mxz);
          end
        end
      end
    end
  end

endmodule
